/* src/sma_pkg.sv */
`timescale 1ns / 1ps

package sma_pkg;

  localparam int unsigned DefStackDepth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned DivW = 48;

  typedef enum logic [4:0] {
    ACT_PUSH  = 5'd0,
    ACT_POP   = 5'd1,
    ACT_PEEK  = 5'd2,
    ACT_DUP   = 5'd3,
    ACT_SWAP  = 5'd4,
    ACT_DROP  = 5'd5,
    ACT_NEG   = 5'd6,
    ACT_INC   = 5'd7,
    ACT_DEC   = 5'd8,
    ACT_TRUNC = 5'd9,
    ACT_NOT   = 5'd10,
    ACT_ADD   = 5'd11,
    ACT_SUB   = 5'd12,
    ACT_MUL   = 5'd13,
    ACT_DIV   = 5'd14,
    ACT_MOD   = 5'd15,
    ACT_AND   = 5'd16,
    ACT_OR    = 5'd17,
    ACT_EQ    = 5'd18,
    ACT_NE    = 5'd19,
    ACT_GT    = 5'd20,
    ACT_LT    = 5'd21,
    ACT_GE    = 5'd22,
    ACT_LE    = 5'd23,
    ACT_CLEAR = 5'd24,
    ACT_SEED  = 5'd25
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_e;

  typedef struct packed {
    shift_e shift;
    logic   load_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [31:0] operand;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [4:0]         depth;
  } out_t;

endpackage

/* src/sma_cell.sv */
`timescale 1ns / 1ps

module sma_cell (
  input  logic                      clk_i,
  input  sma_pkg::cell_ctrl_t       ctrl_i,
  input  logic signed [31:0]        down_val_i,
  input  logic signed [31:0]        up_val_i,
  input  logic signed [31:0]        load_val_i,
  output logic signed [31:0]        val_o
);
  import sma_pkg::*;

  logic signed [DataW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load_en) begin
      val_d = load_val_i;
    end else begin
      case (ctrl_i.shift)
        SH_DOWN: val_d = down_val_i;
        SH_UP:   val_d = up_val_i;
        default: val_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* src/sma_div.sv */
`timescale 1ns / 1ps

module sma_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quot_o,
  output logic [31:0] rem_o
);
  import sma_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic [DataW-1:0] rem_q, rem_d, div_q;
  logic [DivW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW:0]   shifted, diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quot_q[DivW-1]};
    diff    = shifted - {1'b0, div_q};
    if (!diff[DataW]) begin
      rem_d  = diff[DataW-1:0];
      quot_d = {quot_q[DivW-2:0], 1'b1};
    end else begin
      rem_d  = shifted[DataW-1:0];
      quot_d = {quot_q[DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DivW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* src/stack_machine_alu.sv */
`timescale 1ns / 1ps

// operand stack with a q16.16 alu. the stack is a chain of cells, one entry
// per cell, top of stack in cell 0; push and dup shift the chain down, pop,
// drop and binary ops shift it up, so every operation reads only the two
// top cells. one transaction in gives exactly one result transaction out
// (status, value, depth). input is taken only while the block is idle:
// most actions are captured, then executed while the chain shifts; mul
// first registers the 32x32 product, then rounds and saturates; div and
// mod run the 48-step bit-serial divider. a result waiting in the output
// register does not block the next input, but the execute step waits for
// that register to free up. underflow, overflow and divide by zero leave
// the stack unchanged. stack entries have no reset and cells above the
// depth hold stale data.
module stack_machine_alu #(
  parameter int unsigned STACK_DEPTH = sma_pkg::DefStackDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  sma_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output sma_pkg::out_t out_data_o
);
  import sma_pkg::*;

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam logic signed [DataW-1:0] SMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SMin = 32'sh80000000;
  localparam logic signed [DataW-1:0] QOne = 32'sh00010000;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DIV} state_e;

  state_e                  state_q, state_d;
  logic [4:0]              act_q;
  logic signed [DataW-1:0] opnd_q;
  logic signed [63:0]      prod_q, prod_d;
  logic                    neg_q, neg_d, mod_q, mod_d;
  logic [SpW-1:0]          sp_q, sp_d;
  logic                    out_valid_q;
  out_t                    out_q;

  // cell chain
  logic signed [DataW-1:0] cell_val [STACK_DEPTH];
  cell_ctrl_t              ctrl0, ctrl1, ctrl_rest;
  logic signed [DataW-1:0] ld0_val, ld1_val;
  logic signed [DataW-1:0] s0, s1;

  // divider
  logic        div_start, div_done;
  logic [47:0] div_dividend, div_quot;
  logic [31:0] div_divisor, div_rem;
  logic [31:0] mag_a, mag_b;

  // step decisions
  logic                    commit;
  status_e                 st;
  logic signed [DataW-1:0] top_n, value_n;
  logic                    show_s0;
  logic                    out_free;
  logic                    has1, has2, full;
  logic signed [DataW-1:0] un_r, bin_r, mul_r, div_r;
  logic signed [63:0]      mul_round;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh07fffffff) return 32'sh7fffffff;
    if (v < -33'sh080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] truth(input logic b);
    return {15'b0, b, 16'b0};
  endfunction

  assign s0 = cell_val[0];
  assign s1 = cell_val[1];
  assign has1 = sp_q >= SpW'(1);
  assign has2 = sp_q >= SpW'(2);
  assign full = sp_q == SpW'(STACK_DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mag_a = s1[31] ? 32'(-s1) : 32'(s1);
  assign mag_b = s0[31] ? 32'(-s0) : 32'(s0);

  // unary results
  always_comb begin
    case (action_e'(act_q))
      ACT_NEG: un_r = (s0 == SMin) ? SMax : -s0;
      ACT_INC: un_r = sat33(33'(s0) + 33'(QOne));
      ACT_DEC: un_r = sat33(33'(s0) - 33'(QOne));
      ACT_TRUNC: begin
        if (!s0[31] || s0[15:0] == 16'h0) un_r = {s0[31:16], 16'h0};
        else un_r = {s0[31:16], 16'h0} + QOne;
      end
      default: un_r = truth(s0 == '0);
    endcase
  end

  // combinational binary results
  always_comb begin
    case (action_e'(act_q))
      ACT_ADD: bin_r = sat33(33'(s1) + 33'(s0));
      ACT_SUB: bin_r = sat33(33'(s1) - 33'(s0));
      ACT_AND: bin_r = truth(s1 != '0 && s0 != '0);
      ACT_OR:  bin_r = truth(s1 != '0 || s0 != '0);
      ACT_EQ:  bin_r = truth(s1 == s0);
      ACT_NE:  bin_r = truth(s1 != s0);
      ACT_GT:  bin_r = truth(s1 > s0);
      ACT_LT:  bin_r = truth(s1 < s0);
      ACT_GE:  bin_r = truth(s1 >= s0);
      default: bin_r = truth(s1 <= s0);
    endcase
  end

  // mul: round half up, then saturate
  always_comb begin
    mul_round = (prod_q + 64'sd32768) >>> 16;
    if (mul_round > 64'sh7fffffff) mul_r = SMax;
    else if (mul_round < -64'sh80000000) mul_r = SMin;
    else mul_r = mul_round[31:0];
  end

  // div and mod: restore sign, saturate the quotient
  always_comb begin
    if (mod_q) begin
      div_r = neg_q ? -$signed(div_rem) : $signed(div_rem);
    end else if (neg_q) begin
      div_r = (div_quot > 48'h80000000) ? SMin : -$signed(div_quot[31:0]);
    end else begin
      div_r = (div_quot > 48'h7fffffff) ? SMax : $signed(div_quot[31:0]);
    end
  end

  always_comb begin
    div_dividend = (action_e'(act_q) == ACT_MOD) ? {16'h0, mag_a} : {mag_a, 16'h0};
    div_divisor  = mag_b;
  end

  always_comb begin
    state_d   = state_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    mod_d     = mod_q;
    div_start = 1'b0;
    commit    = 1'b0;
    st        = ST_OK;
    sp_d      = sp_q;
    top_n     = s0;
    show_s0   = 1'b0;
    ctrl0     = '{shift: SH_HOLD, load_en: 1'b0};
    ctrl1     = '{shift: SH_HOLD, load_en: 1'b0};
    ctrl_rest = '{shift: SH_HOLD, load_en: 1'b0};
    ld0_val   = s0;
    ld1_val   = s0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
          case (action_e'(act_q))
            ACT_PUSH: begin
              if (full) st = ST_OVERFLOW;
              else begin
                ctrl0 = '{shift: SH_DOWN, load_en: 1'b0};
                ctrl1 = ctrl0;
                ctrl_rest = ctrl0;
                ld0_val = opnd_q;
                top_n = opnd_q;
                sp_d = sp_q + 1'b1;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (!has1) st = ST_UNDERFLOW;
              else begin
                show_s0 = 1'b1;
                if (action_e'(act_q) == ACT_POP) begin
                  ctrl0 = '{shift: SH_UP, load_en: 1'b0};
                  ctrl1 = ctrl0;
                  ctrl_rest = ctrl0;
                  sp_d = sp_q - 1'b1;
                end
              end
            end
            ACT_DUP: begin
              if (!has1) st = ST_UNDERFLOW;
              else if (full) st = ST_OVERFLOW;
              else begin
                ctrl0 = '{shift: SH_DOWN, load_en: 1'b0};
                ctrl1 = ctrl0;
                ctrl_rest = ctrl0;
                sp_d = sp_q + 1'b1;
              end
            end
            ACT_SWAP: begin
              if (!has2) st = ST_UNDERFLOW;
              else begin
                ctrl0 = '{shift: SH_HOLD, load_en: 1'b1};
                ctrl1 = ctrl0;
                ld0_val = s1;
                ld1_val = s0;
                top_n = s1;
              end
            end
            ACT_DROP: begin
              if (!has1) st = ST_UNDERFLOW;
              else begin
                ctrl0 = '{shift: SH_UP, load_en: 1'b0};
                ctrl1 = ctrl0;
                ctrl_rest = ctrl0;
                top_n = s1;
                sp_d = sp_q - 1'b1;
              end
            end
            ACT_NEG, ACT_INC, ACT_DEC, ACT_TRUNC, ACT_NOT: begin
              if (!has1) st = ST_UNDERFLOW;
              else begin
                ctrl0 = '{shift: SH_HOLD, load_en: 1'b1};
                ld0_val = un_r;
                top_n = un_r;
              end
            end
            ACT_MUL: begin
              if (!has2) st = ST_UNDERFLOW;
              else begin
                commit  = 1'b0;
                prod_d  = 64'(s1) * 64'(s0);
                state_d = S_MUL;
              end
            end
            ACT_DIV, ACT_MOD: begin
              if (!has2) st = ST_UNDERFLOW;
              else if (s0 == '0) st = ST_DIV_ZERO;
              else begin
                commit    = 1'b0;
                div_start = 1'b1;
                mod_d     = action_e'(act_q) == ACT_MOD;
                neg_d     = (action_e'(act_q) == ACT_MOD) ? s1[31] : (s1[31] ^ s0[31]);
                state_d   = S_DIV;
              end
            end
            ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_EQ, ACT_NE,
            ACT_GT, ACT_LT, ACT_GE, ACT_LE: begin
              if (!has2) st = ST_UNDERFLOW;
              else begin
                ctrl0 = '{shift: SH_UP, load_en: 1'b1};
                ctrl1 = '{shift: SH_UP, load_en: 1'b0};
                ctrl_rest = ctrl1;
                ld0_val = bin_r;
                top_n = bin_r;
                sp_d = sp_q - 1'b1;
              end
            end
            ACT_CLEAR: sp_d = '0;
            ACT_SEED: begin
              ctrl0 = '{shift: SH_HOLD, load_en: 1'b1};
              ld0_val = opnd_q;
              top_n = opnd_q;
              sp_d = SpW'(1);
            end
            default: ;
          endcase
        end
      end
      S_MUL, S_DIV: begin
        if (out_free && (state_q == S_MUL || div_done)) begin
          commit    = 1'b1;
          state_d   = S_IDLE;
          ctrl0     = '{shift: SH_UP, load_en: 1'b1};
          ctrl1     = '{shift: SH_UP, load_en: 1'b0};
          ctrl_rest = ctrl1;
          ld0_val   = (state_q == S_MUL) ? mul_r : div_r;
          top_n     = ld0_val;
          sp_d      = sp_q - 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (show_s0) value_n = s0;
    else if (sp_d == '0) value_n = '0;
    else value_n = top_n;
  end

  // chain of cells, cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_ctrl_t              ctrl;
    logic signed [DataW-1:0] down_val, up_val, load_val;

    if (i == 0) begin : g_top
      assign ctrl     = ctrl0;
      assign down_val = ld0_val;
      assign load_val = ld0_val;
    end else if (i == 1) begin : g_second
      assign ctrl     = ctrl1;
      assign down_val = cell_val[i-1];
      assign load_val = ld1_val;
    end else begin : g_rest
      assign ctrl     = ctrl_rest;
      assign down_val = cell_val[i-1];
      assign load_val = ld1_val;
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign up_val = '0;
    end else begin : g_mid
      assign up_val = cell_val[i+1];
    end

    sma_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .down_val_i (down_val),
      .up_val_i   (up_val),
      .load_val_i (load_val),
      .val_o      (cell_val[i])
    );
  end

  sma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (commit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q  <= in_data_i.action;
      opnd_q <= in_data_i.operand;
    end
    prod_q <= prod_d;
    neg_q  <= neg_d;
    mod_q  <= mod_d;
    if (commit) begin
      out_q.status <= st;
      out_q.value  <= value_n;
      out_q.depth  <= 5'(sp_d);
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
